/* rtl/jdri_pkg.sv */
// ----------------------------------------------------------------------------
// jdri_pkg
// Types, constants and register codes shared by the joystick deadband and
// rate integrator block and its serial divider.
// ----------------------------------------------------------------------------
package jdri_pkg;

  localparam int NUM_CHANNELS_DEF = 4;

  localparam int CH_W       = 2;
  localparam int SMP_W      = 16;
  localparam int HALF_W     = 12;
  localparam int CMD_W      = 11;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // span between a deadband edge and a travel limit can reach 65535
  localparam int DIV_DEN_W = 17;
  localparam int DIV_QUO_W = 9;
  localparam int DIV_NUM_W = DIV_DEN_W + DIV_QUO_W;

  localparam logic [CMD_W-1:0] CMD_MIN       = 11'd1000;
  localparam logic [CMD_W-1:0] CMD_MID       = 11'd1500;
  localparam logic [CMD_W-1:0] CMD_MAX       = 11'd2000;
  localparam logic [CMD_W-1:0] THR_SLOW_EDGE = 11'd1080;

  localparam logic [8:0]           MAP_SPAN    = 9'd500;
  localparam logic [DIV_DEN_W-1:0] GAIN_SCALE  = DIV_DEN_W'(100);

  localparam logic [3:0] GAIN_THR_FAST = 4'd10;
  localparam logic [3:0] GAIN_THR_SLOW = 4'd3;
  localparam logic [3:0] GAIN_YAW      = 4'd6;
  localparam logic [3:0] GAIN_PR       = 4'd3;

  localparam logic [SMP_W-1:0]  STICK_MIN_RST     = 16'h0000;
  localparam logic [SMP_W-1:0]  STICK_MAX_RST     = 16'h4400;
  localparam logic [SMP_W-1:0]  STICK_CENTER_RST  = 16'h2220;
  localparam logic [SMP_W-1:0]  PITCH_CENTER_RST  = 16'h2240;
  localparam logic [HALF_W-1:0] DEADBAND_HALF_RST = 12'h040;

  localparam logic [CH_W-1:0] CH_THROTTLE = 2'd0;
  localparam logic [CH_W-1:0] CH_YAW      = 2'd1;
  localparam logic [CH_W-1:0] CH_PITCH    = 2'd2;

  typedef enum logic [2:0] {
    REG_STICK_MIN     = 3'd0,
    REG_STICK_MAX     = 3'd1,
    REG_STICK_CENTER  = 3'd2,
    REG_PITCH_CENTER  = 3'd3,
    REG_DEADBAND_HALF = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    TK_MID = 2'd0,
    TK_LO  = 2'd1,
    TK_HI  = 2'd2,
    TK_SAT = 2'd3
  } tgt_kind_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] sample;
  } jdri_in_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel_out;
    logic [CMD_W-1:0] target;
    logic [CMD_W-1:0] command;
  } jdri_out_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QUO_W-1:0] quo;
    logic                 rem_nz;
  } div_rsp_t;

endpackage

/* rtl/jdri_div.sv */
// ----------------------------------------------------------------------------
// jdri_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// DIV_QUO_W bits (top bits of the numerator below the divisor).
// ----------------------------------------------------------------------------
module jdri_div (
  input  logic               clk,
  input  logic               rst_n,
  input  jdri_pkg::div_req_t req,
  output jdri_pkg::div_rsp_t rsp
);
  import jdri_pkg::*;

  localparam int CNT_W = $clog2(DIV_QUO_W + 1);

  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_QUO_W-1:0] numlo_r;
  logic [DIV_QUO_W-1:0] quo_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 qbit;

  always_comb begin
    rem_sh  = {rem_r, numlo_r[DIV_QUO_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    qbit    = (rem_sh >= {1'b0, den_r});
    rem_nxt = qbit ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (req.start) begin
        cnt_r <= CNT_W'(DIV_QUO_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r   <= req.num[DIV_NUM_W-1 -: DIV_DEN_W];
      numlo_r <= req.num[DIV_QUO_W-1:0];
      den_r   <= req.den;
      quo_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r   <= rem_nxt;
      numlo_r <= {numlo_r[DIV_QUO_W-2:0], 1'b0};
      quo_r   <= {quo_r[DIV_QUO_W-2:0], qbit};
    end
  end

  assign rsp.done   = done_r;
  assign rsp.quo    = quo_r;
  assign rsp.rem_nz = |rem_r;

endmodule

/* rtl/joystick_deadband_rate_integrator.sv */
// ----------------------------------------------------------------------------
// joystick_deadband_rate_integrator
// An input beat is taken only in ST_IDLE; in_stall holds off the next beat
// until the result is registered, after two 9-step passes of the shared divider.
// The next input beat may be taken while the previous result is still held.
// Reset (sync, rst_n low): registers to defaults, throttle command 1000,
// other channel commands 1500, output empty.
// ----------------------------------------------------------------------------
module joystick_deadband_rate_integrator #(
  parameter int NUM_CHANNELS = jdri_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  jdri_pkg::jdri_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output jdri_pkg::jdri_out_t                 out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [jdri_pkg::APB_ADDR_W-1:0]     cfg_paddr,
  input  logic [jdri_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic [jdri_pkg::APB_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import jdri_pkg::*;

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MAP  = 8'b0000_0010,
    ST_MUL  = 8'b0000_0100,
    ST_DIV1 = 8'b0000_1000,
    ST_TGT  = 8'b0001_0000,
    ST_KSET = 8'b0010_0000,
    ST_DIV2 = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [SMP_W-1:0]  stick_min_r, stick_max_r, stick_center_r, pitch_center_r;
  logic [HALF_W-1:0] deadband_half_r;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  logic [CH_W-1:0]   ch_r;
  logic [SMP_W-1:0]  smp_r;
  tgt_kind_t         code_r, code_nxt;
  logic [SMP_W-1:0]  x_r, x_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [CMD_W-1:0]  tgt_r, tgt_nxt;
  logic [CMD_W-1:0]  old_r;
  logic              neg_r;
  logic [CMD_W-1:0]  cmd_r [NUM_CHANNELS];
  logic              out_valid_r;
  jdri_out_t         out_r;

  logic              ch_impl, is_yaw, fin_go;
  logic [CH_IDX_W-1:0] ch_idx;

  logic signed [17:0]   s18, mn18, mx18, ctr18, half18, lo18, hi18;
  logic [SMP_W-1:0]     ctr, xlo, xhi;
  logic [DIV_DEN_W-1:0] dlo, dhi;
  logic                 in_lo, in_hi;

  logic signed [11:0] diff;
  logic signed [15:0] diff16, g16, kprod;
  logic [3:0]         gain;
  logic [12:0]        kmag;

  logic signed [12:0] fq, vsum;
  logic [CMD_W-1:0]   cmd_calc, cmd_fin;

  div_req_t div_req;
  div_rsp_t div_rsp;

  jdri_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // configuration port
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_min_r     <= STICK_MIN_RST;
      stick_max_r     <= STICK_MAX_RST;
      stick_center_r  <= STICK_CENTER_RST;
      pitch_center_r  <= PITCH_CENTER_RST;
      deadband_half_r <= DEADBAND_HALF_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STICK_MIN:     stick_min_r     <= cfg_pwdata[SMP_W-1:0];
        REG_STICK_MAX:     stick_max_r     <= cfg_pwdata[SMP_W-1:0];
        REG_STICK_CENTER:  stick_center_r  <= cfg_pwdata[SMP_W-1:0];
        REG_PITCH_CENTER:  pitch_center_r  <= cfg_pwdata[SMP_W-1:0];
        REG_DEADBAND_HALF: deadband_half_r <= cfg_pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STICK_MIN:     cfg_prdata = APB_DATA_W'(stick_min_r);
      REG_STICK_MAX:     cfg_prdata = APB_DATA_W'(stick_max_r);
      REG_STICK_CENTER:  cfg_prdata = APB_DATA_W'(stick_center_r);
      REG_PITCH_CENTER:  cfg_prdata = APB_DATA_W'(pitch_center_r);
      REG_DEADBAND_HALF: cfg_prdata = APB_DATA_W'(deadband_half_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // sequencer
  assign fin_go   = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MAP;
      ST_MAP:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DIV1;
      ST_DIV1: if (div_rsp.done) state_nxt = ST_TGT;
      ST_TGT:  state_nxt = ST_KSET;
      ST_KSET: state_nxt = ST_DIV2;
      ST_DIV2: if (div_rsp.done) state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign ch_impl = ({30'b0, ch_r} < 32'(NUM_CHANNELS));
  assign ch_idx  = CH_IDX_W'(ch_r);
  assign is_yaw  = (ch_r == CH_YAW);

  // range classification
  always_comb begin
    ctr    = (ch_r == CH_PITCH) ? pitch_center_r : stick_center_r;
    s18    = $signed({2'b0, smp_r});
    mn18   = $signed({2'b0, stick_min_r});
    mx18   = $signed({2'b0, stick_max_r});
    ctr18  = $signed({2'b0, ctr});
    half18 = $signed({6'b0, deadband_half_r});
    lo18   = ctr18 - half18;
    hi18   = ctr18 + half18;
    in_lo  = (s18 >= mn18) && (s18 <= lo18);
    in_hi  = (s18 <= mx18) && (s18 >= hi18);
    dlo    = DIV_DEN_W'(lo18 - mn18);
    dhi    = DIV_DEN_W'(mx18 - hi18);
    xlo    = 16'(s18 - mn18);
    xhi    = 16'(s18 - hi18);
    code_nxt = TK_MID;
    x_nxt    = xlo;
    den_nxt  = dlo;
    if (smp_r[SMP_W-1]) begin
      code_nxt = TK_SAT;
    end else if (in_lo) begin
      code_nxt = (dlo == '0) ? TK_MID : TK_LO;
    end else if (in_hi) begin
      code_nxt = (dhi == '0) ? TK_MID : TK_HI;
      x_nxt    = xhi;
      den_nxt  = dhi;
    end else if (s18 > mx18) begin
      code_nxt = TK_SAT;
    end
  end

  // target from first quotient
  always_comb begin
    case (code_r)
      TK_SAT:  tgt_nxt = is_yaw ? CMD_MIN : CMD_MAX;
      TK_LO:   tgt_nxt = is_yaw ? (CMD_MAX - CMD_W'(div_rsp.quo))
                                : (CMD_MIN + CMD_W'(div_rsp.quo));
      TK_HI:   tgt_nxt = is_yaw ? (CMD_MID - CMD_W'(div_rsp.quo))
                                : (CMD_MID + CMD_W'(div_rsp.quo));
      default: tgt_nxt = CMD_MID;
    endcase
  end

  // integrator step: gain * (target - 1500), divided by 100
  always_comb begin
    if (ch_r == CH_THROTTLE) begin
      gain = (old_r < THR_SLOW_EDGE) ? GAIN_THR_FAST : GAIN_THR_SLOW;
    end else if (is_yaw) begin
      gain = GAIN_YAW;
    end else begin
      gain = GAIN_PR;
    end
    diff   = $signed({1'b0, tgt_r}) - $signed({1'b0, CMD_MID});
    diff16 = 16'(diff);
    g16    = $signed({12'b0, gain});
    kprod  = diff16 * g16;
    kmag   = kprod[15] ? 13'(-kprod) : 13'(kprod);
  end

  always_comb begin
    div_req.start = (state_r == ST_MUL) || (state_r == ST_KSET);
    if (state_r == ST_MUL) begin
      div_req.num = DIV_NUM_W'(x_r) * DIV_NUM_W'(MAP_SPAN);
      div_req.den = den_r;
    end else begin
      div_req.num = DIV_NUM_W'(kmag);
      div_req.den = GAIN_SCALE;
    end
  end

  // floor division result, overrides and clamp
  always_comb begin
    fq = neg_r ? -($signed(13'(div_rsp.quo)) + $signed(13'(div_rsp.rem_nz)))
               : $signed(13'(div_rsp.quo));
    vsum = $signed({2'b0, old_r}) + fq;
    if (vsum < $signed({2'b0, CMD_MIN})) begin
      cmd_calc = CMD_MIN;
    end else if (vsum > $signed({2'b0, CMD_MAX})) begin
      cmd_calc = CMD_MAX;
    end else begin
      cmd_calc = vsum[CMD_W-1:0];
    end
    if (ch_r == CH_THROTTLE && tgt_r == CMD_MIN) begin
      cmd_calc = CMD_MIN;
    end else if (ch_r != CH_THROTTLE && tgt_r == CMD_MID) begin
      cmd_calc = CMD_MID;
    end
    cmd_fin = ch_impl ? cmd_calc : CMD_MID;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cmd_r[i] <= (i == 0) ? CMD_MIN : CMD_MID;
      end
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (fin_go && ch_impl) begin
        cmd_r[ch_idx] <= cmd_fin;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      ch_r  <= in_data.channel;
      smp_r <= in_data.sample;
    end
    if (state_r == ST_MAP) begin
      code_r <= code_nxt;
      x_r    <= x_nxt;
      den_r  <= den_nxt;
    end
    if (state_r == ST_TGT) begin
      tgt_r <= tgt_nxt;
      old_r <= ch_impl ? cmd_r[ch_idx] : CMD_MID;
    end
    if (state_r == ST_KSET) begin
      neg_r <= kprod[15];
    end
    if (fin_go) begin
      out_r.channel_out <= ch_r;
      out_r.target      <= tgt_r;
      out_r.command     <= cmd_fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result beat raised outside the final step");

  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.command >= CMD_MIN && out_r.command <= CMD_MAX))
    else $error("command out of range");

  a_tgt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.target >= CMD_MIN && out_r.target <= CMD_MAX))
    else $error("target out of range");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV1 || state_r == ST_DIV2))
    else $error("divider finished outside a divide step");

endmodule
